// ----- rtl/adaptive_weighted_move_selector_assert.svh -----
// Assertion helpers; expect clk and rst_n in the enclosing module.
`ifndef ADAPTIVE_WEIGHTED_MOVE_SELECTOR_ASSERT_SVH
`define ADAPTIVE_WEIGHTED_MOVE_SELECTOR_ASSERT_SVH

// same-cycle implication
`define AWMS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AWMS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/awms_pkg.sv -----
`default_nettype none
package awms_pkg;

  localparam int WW   = 17;  // weight, Q0.16 plus one
  localparam int SUMW = 48;
  localparam int CNTW = 26;
  localparam int STW  = SUMW + CNTW;
  localparam int DVW  = 64;  // divider dividend / quotient
  localparam int DSW  = 40;  // divider divisor
  localparam int MPW  = 57;  // multiplier product
  localparam int MBW  = 17;  // multiplier short operand

  localparam logic [16:0]     ONE_Q16   = 17'd65536;
  localparam logic [11:0]     FLOOR_Q16 = 12'd3277;
  localparam logic [16:0]     CAP_Q16   = 17'd52429;
  localparam logic [CNTW-1:0] COUNT_ONE = 26'd256;
  localparam logic [SUMW-1:0] SUM_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [CNTW-1:0] COUNT_MAX = 26'h3FF_FFFF;
  localparam logic [15:0]     PASS_MAX  = 16'hFFFF;

  localparam logic [1:0] CFG_ADAPT_EN = 2'd0;
  localparam logic [1:0] CFG_ACTIVE   = 2'd1;
  localparam logic [1:0] CFG_PINNED   = 2'd2;

  localparam logic OP_PICK   = 1'b0;
  localparam logic OP_REWARD = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PICK,
    ST_OUT,
    ST_REW,
    ST_A_GO,
    ST_A_CHK,
    ST_A_DIV,
    ST_A_END,
    ST_FL_DIV,
    ST_NORM,
    ST_G_DIV,
    ST_SQRT,
    ST_B_CHK,
    ST_B_MDIV,
    ST_B_RMUL,
    ST_B_QDIV,
    ST_B_TMUL,
    ST_B_TDIV,
    ST_B_ADJ,
    ST_B_GMUL
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/adaptive_weighted_move_selector.sv -----
`default_nettype none
// Adaptive weighted move selector.
// Input channel (in_valid / in_stall): one word per item. opcode pick carries
// uniform_draw and returns one word on the output channel with picked_move;
// opcode reward carries move_index and reward_value and returns nothing.
// Items are taken one at a time: in_stall is high while an item is in work.
// A pick walks the weight memory one move per cycle and then places the
// result in the output register. A reward reads, then writes back, the
// statistics.
// Every ADAPT_INTERVAL-th reward with adaptation enabled runs a pass through
// a shared bit-serial divider, multiplier and square root, with one more
// division when the floor share has to be divided down.
// The output register frees the input side: a new item is taken while a
// result waits; a pick that finishes while out_stall holds the previous word
// waits until that word is taken.
// Config writes (cfg_valid / cfg_ready, always ready) must go in while idle
// (not enforced). Reset (rst_n low, synchronous) restores equal weights, zero
// statistics and register defaults; memories start valid via per-entry bits.
`include "adaptive_weighted_move_selector_assert.svh"
module adaptive_weighted_move_selector #(
  parameter int NUM_MOVES      = 8,
  parameter int ADAPT_INTERVAL = 200
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_opcode,
  input  wire logic [15:0] in_uniform_draw,
  input  wire logic [2:0]  in_move_index,
  input  wire logic [31:0] in_reward_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_picked_move,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import awms_pkg::*;

  localparam int IW   = (NUM_MOVES > 1) ? $clog2(NUM_MOVES) : 1;
  localparam int NAW  = $clog2(NUM_MOVES + 1);
  localparam int CW   = WW + NAW;
  localparam int PSW  = WW + NAW;
  localparam int SW   = 56 + NAW;
  localparam int SHW  = $clog2(SW - 39);
  localparam int TW   = $clog2(ADAPT_INTERVAL + 1);
  localparam logic [IW-1:0] LAST     = IW'(NUM_MOVES - 1);
  localparam logic [WW-1:0] W_RESET  = WW'(65536 / NUM_MOVES);
  localparam logic [TW-1:0] TALLY_END = TW'(ADAPT_INTERVAL - 1);

  // memories
  logic [WW-1:0]  wt_mem_r [NUM_MOVES];
  logic [STW-1:0] st_mem_r [NUM_MOVES];
  logic [WW-1:0]  wt_q_r;
  logic [STW-1:0] st_q_r;
  logic           wt_qv_r, st_qv_r;
  logic [NUM_MOVES-1:0] wv_r, sv_r;

  // control and datapath registers
  state_t          state_r, state_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   cum_r, cum_nxt;
  logic [15:0]     draw_r, draw_nxt;
  logic [31:0]     rv_r, rv_nxt;
  logic [IW-1:0]   pick_r, pick_nxt;
  logic [TW-1:0]   tally_r, tally_nxt;
  logic [15:0]     ac_r, ac_nxt;
  logic [PSW-1:0]  pin_sum_r, pin_sum_nxt;
  logic [NAW-1:0]  na_r, na_nxt;
  logic [SW-1:0]   s_r, s_nxt;
  logic [SHW-1:0]  shift_r, shift_nxt;
  logic [11:0]     fl_r, fl_nxt;
  logic [16:0]     rest_r, rest_nxt;
  logic [16:0]     avail_r, avail_nxt;
  logic [16:0]     g_r, g_nxt;
  logic [18:0]     tgt_r, tgt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [2:0]      out_move_r, out_move_nxt;
  logic            adapt_en_r;
  logic [7:0]      act_r, pin_r;

  // serial units
  logic [DVW-1:0]  div_quo_r;
  logic [DSW-1:0]  div_rem_r, div_dsr_r;
  logic [6:0]      div_cnt_r;
  logic [MPW-1:0]  mul_a_r, mul_p_r;
  logic [MBW-1:0]  mul_b_r;
  logic [4:0]      mul_cnt_r;
  logic [32:0]     sq_x_r, sq_res_r, sq_bit_r;

  logic            div_start, mul_start, sq_start;
  logic [DVW-1:0]  div_dvd;
  logic [DSW-1:0]  div_dsr;
  logic [MPW-1:0]  mul_a;
  logic [MBW-1:0]  mul_b;
  logic            div_done, mul_done;
  logic [DSW:0]    div_t;
  logic            div_ge;
  logic [32:0]     sq_sum;

  logic            wt_we, st_we;
  logic [WW-1:0]   wt_wdata;
  logic [STW-1:0]  st_wdata;

  // read-side views
  logic [WW-1:0]   wt_rd;
  logic [STW-1:0]  st_rd;
  logic [SUMW-1:0] sum_rd;
  logic [CNTW-1:0] cnt_rd;
  logic [31:0]     act_ext, pin_ext;
  logic            cur_pin, cur_act;
  logic [IW-1:0]   fb_move;
  logic            mv_ok;
  logic [CW-1:0]   cum_sum;
  logic [SUMW:0]   sum_add;
  logic [SUMW-1:0] sum_sat;
  logic [CNTW-1:0] cnt_sat;
  logic [STW-1:0]  st_half;
  logic [17:0]     fl_na_floor, fl_na;
  logic [55:0]     mean_sh;
  logic [18:0]     w19, diff, w_new;

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_picked_move = out_move_r;
  assign cfg_ready       = 1'b1;

  assign wt_rd   = wt_qv_r ? wt_q_r : W_RESET;
  assign st_rd   = st_qv_r ? st_q_r : '0;
  assign sum_rd  = st_rd[STW-1:CNTW];
  assign cnt_rd  = st_rd[CNTW-1:0];
  assign act_ext = 32'(act_r);
  assign pin_ext = 32'(pin_r);
  assign cur_pin = pin_ext[idx_r];
  assign cur_act = act_ext[idx_r];
  assign mv_ok   = (32'(in_move_index) < NUM_MOVES);

  assign cum_sum = cum_r + CW'(wt_rd);
  assign sum_add = (SUMW+1)'(sum_rd) + (SUMW+1)'(rv_r);
  assign sum_sat = sum_add[SUMW] ? SUM_MAX : sum_add[SUMW-1:0];
  assign cnt_sat = (cnt_rd > COUNT_MAX - COUNT_ONE) ? COUNT_MAX : cnt_rd + COUNT_ONE;
  assign st_half = {sum_rd >> 1, cnt_rd >> 1};

  assign fl_na_floor = 18'(FLOOR_Q16) * 18'(na_r);
  assign fl_na       = 18'(fl_r) * 18'(na_r);
  assign mean_sh     = div_quo_r[55:0] >> shift_r;

  assign w19   = 19'(wt_rd);
  assign diff  = (tgt_r >= w19) ? tgt_r - w19 : w19 - tgt_r;
  assign w_new = (tgt_r >= w19) ? w19 + mul_p_r[34:16] : w19 - mul_p_r[34:16];

  assign div_done = (div_cnt_r == 7'd0);
  assign mul_done = (mul_cnt_r == 5'd0);
  assign div_t    = {div_rem_r, div_quo_r[DVW-1]};
  assign div_ge   = (div_t >= {1'b0, div_dsr_r});
  assign sq_sum   = sq_res_r + sq_bit_r;

  // highest active move for the fall-through case
  always_comb begin
    fb_move = '0;
    for (int m = 0; m < NUM_MOVES; m++) begin
      if (act_ext[m]) fb_move = IW'(m);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cum_nxt       = cum_r;
    draw_nxt      = draw_r;
    rv_nxt        = rv_r;
    pick_nxt      = pick_r;
    tally_nxt     = tally_r;
    ac_nxt        = ac_r;
    pin_sum_nxt   = pin_sum_r;
    na_nxt        = na_r;
    s_nxt         = s_r;
    shift_nxt     = shift_r;
    fl_nxt        = fl_r;
    rest_nxt      = rest_r;
    avail_nxt     = avail_r;
    g_nxt         = g_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = out_valid_r;
    out_move_nxt  = out_move_r;
    wt_we         = 1'b0;
    st_we         = 1'b0;
    wt_wdata      = w_new[WW-1:0];
    st_wdata      = st_half;
    div_start     = 1'b0;
    div_dvd       = '0;
    div_dsr       = '0;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sq_start      = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_PICK) begin
            draw_nxt  = in_uniform_draw;
            cum_nxt   = '0;
            idx_nxt   = '0;
            state_nxt = ST_PICK;
          end else if (mv_ok) begin
            rv_nxt    = in_reward_value;
            idx_nxt   = IW'(in_move_index);
            state_nxt = ST_REW;
          end
        end
      end
      ST_PICK: begin
        cum_nxt = cum_sum;
        if (CW'(draw_r) < cum_sum) begin
          pick_nxt  = idx_r;
          state_nxt = ST_OUT;
        end else if (idx_r == LAST) begin
          pick_nxt  = fb_move;
          state_nxt = ST_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_move_nxt  = 3'(pick_r);
          state_nxt     = ST_IDLE;
        end
      end
      ST_REW: begin
        st_we    = 1'b1;
        st_wdata = {sum_sat, cnt_sat};
        if (tally_r == TALLY_END) begin
          tally_nxt = '0;
          if (adapt_en_r) begin
            ac_nxt      = (ac_r == PASS_MAX) ? ac_r : ac_r + 16'd1;
            pin_sum_nxt = '0;
            na_nxt      = '0;
            s_nxt       = '0;
            shift_nxt   = '0;
            state_nxt   = ST_A_GO;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          tally_nxt = tally_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_A_GO: begin
        // an idle state so the first read sees the reward write-back
        idx_nxt   = '0;
        state_nxt = ST_A_CHK;
      end
      ST_A_CHK: begin
        if (cur_pin) pin_sum_nxt = pin_sum_r + PSW'(wt_rd);
        else if (cur_act) na_nxt = na_r + 1'b1;
        if (!cur_pin && cur_act && cnt_rd != '0) begin
          div_start = 1'b1;
          div_dvd   = {8'd0, sum_rd, 8'd0};
          div_dsr   = DSW'(cnt_rd);
          state_nxt = ST_A_DIV;
        end else if (idx_r == LAST) begin
          state_nxt = ST_A_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_A_DIV: begin
        if (div_done) begin
          s_nxt = s_r + SW'(div_quo_r[55:0]);
          if (idx_r == LAST) begin
            state_nxt = ST_A_END;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_A_CHK;
          end
        end
      end
      ST_A_END: begin
        avail_nxt = (pin_sum_r >= PSW'(ONE_Q16)) ? 17'd0 : 17'(PSW'(ONE_Q16) - pin_sum_r);
        if (na_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (fl_na_floor > 18'(CAP_Q16)) begin
          div_start = 1'b1;
          div_dvd   = DVW'(CAP_Q16);
          div_dsr   = DSW'(na_r);
          state_nxt = ST_FL_DIV;
        end else begin
          fl_nxt    = FLOOR_Q16;
          state_nxt = ST_NORM;
        end
      end
      ST_FL_DIV: begin
        if (div_done) begin
          fl_nxt    = div_quo_r[11:0];
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        rest_nxt = 17'(18'(ONE_Q16) - fl_na);
        if (|s_r[SW-1:40]) begin
          s_nxt     = s_r >> 1;
          shift_nxt = shift_r + 1'b1;
        end else begin
          div_start = 1'b1;
          div_dvd   = DVW'(64'h1_0000_0000);
          div_dsr   = DSW'(ac_r);
          state_nxt = ST_G_DIV;
        end
      end
      ST_G_DIV: begin
        if (div_done) begin
          sq_start  = 1'b1;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_bit_r == '0) begin
          g_nxt     = sq_res_r[16:0];
          idx_nxt   = '0;
          state_nxt = ST_B_CHK;
        end
      end
      ST_B_CHK: begin
        if (cur_pin) begin
          st_we = 1'b1;
          if (idx_r == LAST) state_nxt = ST_IDLE;
          else idx_nxt = idx_r + 1'b1;
        end else if (!cur_act) begin
          tgt_nxt   = '0;
          state_nxt = ST_B_ADJ;
        end else if (s_r == '0) begin
          div_start = 1'b1;
          div_dvd   = DVW'(avail_r);
          div_dsr   = DSW'(na_r);
          state_nxt = ST_B_TDIV;
        end else if (cnt_rd != '0) begin
          div_start = 1'b1;
          div_dvd   = {8'd0, sum_rd, 8'd0};
          div_dsr   = DSW'(cnt_rd);
          state_nxt = ST_B_MDIV;
        end else begin
          // zero mean: share term vanishes
          mul_start = 1'b1;
          mul_a     = MPW'(fl_r);
          mul_b     = avail_r;
          state_nxt = ST_B_TMUL;
        end
      end
      ST_B_MDIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = MPW'(mean_sh[39:0]);
          mul_b     = rest_r;
          state_nxt = ST_B_RMUL;
        end
      end
      ST_B_RMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_dvd   = DVW'(mul_p_r);
          div_dsr   = s_r[DSW-1:0];
          state_nxt = ST_B_QDIV;
        end
      end
      ST_B_QDIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = MPW'(18'(fl_r) + 18'(div_quo_r[16:0]));
          mul_b     = avail_r;
          state_nxt = ST_B_TMUL;
        end
      end
      ST_B_TMUL: begin
        if (mul_done) begin
          tgt_nxt   = mul_p_r[34:16];
          state_nxt = ST_B_ADJ;
        end
      end
      ST_B_TDIV: begin
        if (div_done) begin
          tgt_nxt   = 19'(div_quo_r[16:0]);
          state_nxt = ST_B_ADJ;
        end
      end
      ST_B_ADJ: begin
        mul_start = 1'b1;
        mul_a     = MPW'(diff);
        mul_b     = g_r;
        state_nxt = ST_B_GMUL;
      end
      ST_B_GMUL: begin
        if (mul_done) begin
          wt_we = 1'b1;
          st_we = 1'b1;
          if (idx_r == LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_B_CHK;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tally_r     <= '0;
      ac_r        <= '0;
      adapt_en_r  <= 1'b0;
      act_r       <= 8'hFF;
      pin_r       <= 8'h00;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tally_r     <= tally_nxt;
      ac_r        <= ac_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_ADAPT_EN: adapt_en_r <= cfg_data[0];
          CFG_ACTIVE:   act_r      <= cfg_data;
          CFG_PINNED:   pin_r      <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cum_r     <= cum_nxt;
    draw_r    <= draw_nxt;
    rv_r      <= rv_nxt;
    pick_r    <= pick_nxt;
    pin_sum_r <= pin_sum_nxt;
    na_r      <= na_nxt;
    s_r       <= s_nxt;
    shift_r   <= shift_nxt;
    fl_r      <= fl_nxt;
    rest_r    <= rest_nxt;
    avail_r   <= avail_nxt;
    g_r       <= g_nxt;
    tgt_r     <= tgt_nxt;
    out_move_r <= out_move_nxt;
  end

  // weight and statistics memories, registered read
  always_ff @(posedge clk) begin
    wt_q_r  <= wt_mem_r[idx_nxt];
    st_q_r  <= st_mem_r[idx_nxt];
    wt_qv_r <= wv_r[idx_nxt];
    st_qv_r <= sv_r[idx_nxt];
    if (wt_we) wt_mem_r[idx_r] <= wt_wdata;
    if (st_we) st_mem_r[idx_r] <= st_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
      sv_r <= '0;
    end else begin
      if (wt_we) wv_r[idx_r] <= 1'b1;
      if (st_we) sv_r[idx_r] <= 1'b1;
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (div_start) begin
      div_quo_r <= div_dvd;
      div_rem_r <= '0;
      div_dsr_r <= div_dsr;
      div_cnt_r <= 7'd64;
    end else if (div_cnt_r != 7'd0) begin
      div_quo_r <= {div_quo_r[DVW-2:0], div_ge};
      div_rem_r <= div_ge ? DSW'(div_t - {1'b0, div_dsr_r}) : div_t[DSW-1:0];
      div_cnt_r <= div_cnt_r - 7'd1;
    end
  end

  // shift-add multiplier, one bit of the short operand per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
    end else if (mul_start) begin
      mul_a_r   <= mul_a;
      mul_b_r   <= mul_b;
      mul_p_r   <= '0;
      mul_cnt_r <= 5'(MBW);
    end else if (mul_cnt_r != 5'd0) begin
      if (mul_b_r[0]) mul_p_r <= mul_p_r + mul_a_r;
      mul_a_r   <= mul_a_r << 1;
      mul_b_r   <= mul_b_r >> 1;
      mul_cnt_r <= mul_cnt_r - 5'd1;
    end
  end

  // digit-by-digit square root of the 33-bit quotient
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bit_r <= '0;
    end else if (sq_start) begin
      sq_x_r   <= div_quo_r[32:0];
      sq_res_r <= '0;
      sq_bit_r <= 33'h1_0000_0000;
    end else if (sq_bit_r != '0) begin
      if (sq_x_r >= sq_sum) begin
        sq_x_r   <= sq_x_r - sq_sum;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end

  `AWMS_ASSERT_NXT(a_pick_enter, in_valid && !in_stall && in_opcode == OP_PICK, state_r == ST_PICK, "pick did not start walk")
  `AWMS_ASSERT_IMP(a_pick_idx, state_r == ST_PICK, 32'(idx_r) < NUM_MOVES, "pick walk out of range")
  `AWMS_ASSERT_IMP(a_idle_nowrite, state_r == ST_IDLE, !(wt_we || st_we), "memory write while idle")
  `AWMS_ASSERT_NXT(a_no_pass_off, state_r == ST_REW && tally_r == TALLY_END && !adapt_en_r, state_r == ST_IDLE, "pass started while disabled")

endmodule
`default_nettype wire
